@@ design/stiir_pkg.sv @@
package stiir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;
    localparam int COEF_FRAC  = 20;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int QUOT_W     = ACC_W - COEF_FRAC;
    localparam int HIST_DEPTH = 3;
    localparam int CFG_IDX_W  = 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    typedef struct packed {
        t_coef c_in;
        t_coef c_fb1;
        t_coef c_fb2;
        t_coef c_fb3;
    } t_coefs;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_INPUT          = 2'd0,
        REG_COEF_FEEDBACK_ONE   = 2'd1,
        REG_COEF_FEEDBACK_TWO   = 2'd2,
        REG_COEF_FEEDBACK_THREE = 2'd3
    } t_reg_idx;

endpackage

@@ design/stiir_chan.sv @@
module stiir_chan
    import stiir_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_coefs  i_coefs,
    input  t_sample i_sample,
    output t_sample o_sample
);

    localparam logic [ACC_W-1:0] FRAC_MASK =
        {{(ACC_W-COEF_FRAC){1'b0}}, {COEF_FRAC{1'b1}}};
    localparam t_sample SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    t_sample r_hist [HIST_DEPTH];

    logic signed [PROD_W-1:0] prod_x, prod_1, prod_2, prod_3;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_biased;
    logic signed [QUOT_W-1:0] quot;
    logic                     fits;
    t_sample                  result;

    always_comb begin
        prod_x = PROD_W'(i_coefs.c_in)  * PROD_W'(i_sample);
        prod_1 = PROD_W'(i_coefs.c_fb1) * PROD_W'(r_hist[0]);
        prod_2 = PROD_W'(i_coefs.c_fb2) * PROD_W'(r_hist[1]);
        prod_3 = PROD_W'(i_coefs.c_fb3) * PROD_W'(r_hist[2]);
        acc    = ACC_W'(prod_x) + ACC_W'(prod_1) + ACC_W'(prod_2) + ACC_W'(prod_3);
        // round toward zero: bias negative sums before the arithmetic shift
        acc_biased = acc + (acc[ACC_W-1] ? $signed(FRAC_MASK) : $signed(ACC_W'(0)));
        quot       = acc_biased[ACC_W-1:COEF_FRAC];
        fits       = (quot[QUOT_W-1:SAMPLE_W-1] == {(QUOT_W-SAMPLE_W+1){1'b0}}) ||
                     (quot[QUOT_W-1:SAMPLE_W-1] == {(QUOT_W-SAMPLE_W+1){1'b1}});
        if (fits) begin
            result = quot[SAMPLE_W-1:0];
        end else if (quot[QUOT_W-1]) begin
            result = SAT_MIN;
        end else begin
            result = SAT_MAX;
        end
    end

    assign o_sample = result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_advance) begin
            r_hist[0] <= result;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

endmodule

@@ design/stiir_skid.sv @@
module stiir_skid
    import stiir_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_sample i_left,
    input  t_sample i_right,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_sample o_left,
    output t_sample o_right
);

    logic    r_out_valid, r_skid_valid;
    logic    n_out_valid, n_skid_valid;
    t_sample r_out_left, r_out_right, r_skid_left, r_skid_right;
    logic    take;
    logic    load_out, load_skid, move_skid;

    always_comb begin
        take      = r_out_valid && !i_stall;
        load_out  = i_load && (!r_out_valid || take);
        load_skid = i_load && r_out_valid && !take;
        move_skid = take && r_skid_valid;
        n_out_valid  = load_out || move_skid || (r_out_valid && !take);
        n_skid_valid = load_skid || (r_skid_valid && !move_skid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_skid) begin
            r_out_left  <= r_skid_left;
            r_out_right <= r_skid_right;
        end else if (load_out) begin
            r_out_left  <= i_left;
            r_out_right <= i_right;
        end
        if (load_skid) begin
            r_skid_left  <= i_left;
            r_skid_right <= i_right;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_left  = r_out_left;
    assign o_right = r_out_right;

endmodule

@@ design/stereo_third_order_iir_lowpass_top.sv @@
// channel  direction  handshake            payload
// input    in         i_valid / o_stall    i_left_in, i_right_in
// output   out        o_valid / i_stall    o_left_out, o_right_out
// config   in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One sample pair per cycle while o_stall is low; the result is registered
// in the output buffer. Per-sample feedback runs through the history registers.
// Synchronous active-low reset clears coefficients, history and valids.
// A two-entry output buffer keeps taking input while one result waits;
// o_stall rises only when both entries are held.
module stereo_third_order_iir_lowpass_top
    import stiir_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_sample              i_left_in,
    input  t_sample              i_right_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_sample              o_left_out,
    output t_sample              o_right_out
);

    t_coefs  r_coefs;
    logic    accept;
    logic    skid_full;
    t_sample left_y, right_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_COEF_INPUT:          r_coefs.c_in  <= i_cfg_data;
                REG_COEF_FEEDBACK_ONE:   r_coefs.c_fb1 <= i_cfg_data;
                REG_COEF_FEEDBACK_TWO:   r_coefs.c_fb2 <= i_cfg_data;
                REG_COEF_FEEDBACK_THREE: r_coefs.c_fb3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = skid_full;
    assign accept  = i_valid && !skid_full;

    stiir_chan u_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_coefs   (r_coefs),
        .i_sample  (i_left_in),
        .o_sample  (left_y)
    );

    stiir_chan u_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_coefs   (r_coefs),
        .i_sample  (i_right_in),
        .o_sample  (right_y)
    );

    stiir_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_left  (left_y),
        .i_right (right_y),
        .o_full  (skid_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_left  (o_left_out),
        .o_right (o_right_out)
    );

`ifndef SYNTH
    a_full_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid entry held without output entry");

    a_transfer_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted sample produced no result");

    a_drain_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && !i_stall) |=> (o_valid && !o_stall))
        else $error("skid entry lost on drain");
`endif

endmodule
